@@ sv/spbcm_pkg.sv @@
// Shared types and constants for the spinor bilinear complex MAC.
package spbcm_pkg;

	// Field widths of the item and result words.
	localparam int AmpW = 16;
	localparam int AccW = 40;

	// Configuration register file.
	localparam int CfgRegs  = 8;
	localparam int CfgIdxW  = $clog2(CfgRegs);
	localparam int CfgAddrW = CfgIdxW + 2;
	localparam int CfgDataW = 32;

	// Default number of spinor components.
	localparam int DefSpinorCount = 2;

	// Internal arithmetic widths.
	localparam int ProdW = 2 * AmpW;           // 16x16 amplitude product
	localparam int SumW  = ProdW + 2;          // sum of four products
	localparam int MixW  = AmpW + SumW;        // coefficient times sum
	localparam int CombW = MixW + 1;           // difference or sum of two
	localparam int RndShift = 12;
	localparam logic signed [CombW-1:0] RndHalf = CombW'(2048);

	typedef logic signed [AmpW-1:0] amp_t;
	typedef logic signed [AccW-1:0] acc_t;
	typedef amp_t [CfgRegs-1:0] coef_bank_t;

	typedef struct packed {
		amp_t kbase_re;
		amp_t kbase_im;
		amp_t kdir_re;
		amp_t kdir_im;
		amp_t kpbase_re;
		amp_t kpbase_im;
		amp_t kpdir_re;
		amp_t kpdir_im;
		acc_t prior_re;
		acc_t prior_im;
		logic spinor_row;
		logic spinor_col;
	} item_t;

	typedef struct packed {
		acc_t sum_re;
		acc_t sum_im;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mix;
		logic acc;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
	} dp_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MIX  = 3'b010,
		ST_ACC  = 3'b100
	} state_t;

endpackage

@@ sv/spbcm_if.sv @@
// Valid/ready channels for item words and result words.
interface spbcm_item_if import spbcm_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t word;

	modport source(output valid, output word, input ready);
	modport sink(input valid, input word, output ready);
endinterface

interface spbcm_result_if import spbcm_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t word;

	modport source(output valid, output word, input ready);
	modport sink(input valid, input word, output ready);
endinterface

@@ sv/spbcm_cfg.sv @@
// APB-style coefficient register file.
module spbcm_cfg import spbcm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready,
	output coef_bank_t          coefs
);

	logic [CfgIdxW-1:0] idx;
	coef_bank_t         regs_q;

	assign idx    = paddr[CfgAddrW-1:2];
	assign pready = 1'b1;
	assign coefs  = regs_q;

	// A write lands in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (psel && penable && pwrite) begin
			regs_q[idx] <= pwdata[AmpW-1:0];
		end
	end

	// Reads return the coefficient sign-extended to the bus width.
	assign prdata = CfgDataW'(signed'(regs_q[idx]));

endmodule

@@ sv/spbcm_ctrl.sv @@
// Controller: sequences one item through the datapath and owns the result valid.
module spbcm_ctrl import spbcm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	output logic       result_valid,
	input  logic       result_ready,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd,
	output logic       out_load
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   acc_go;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

	// The last pair waits until the output register is free.
	assign acc_go = (state_q == ST_ACC) && (!stat.last || !out_valid_q || result_ready);

	always_comb begin
		cmd.load = item_valid && item_ready;
		cmd.mix  = (state_q == ST_MIX);
		cmd.acc  = acc_go;
		out_load = acc_go && stat.last;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_MIX;
			end
			ST_MIX: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (acc_go) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/spbcm_dp.sv @@
// Datapath: amplitude products, coefficient multiply, rounding and saturating accumulate.
module spbcm_dp import spbcm_pkg::*; #(
	parameter int SPINOR_COUNT = DefSpinorCount
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	input  logic       out_load,
	input  item_t      item,
	input  coef_bank_t coefs,
	output dp_stat_t   stat,
	output result_t    result
);

	localparam logic LastIdx = 1'(SPINOR_COUNT - 1);

	logic signed [ProdW-1:0] p_s1 [8];
	amp_t                    f_re_s1, f_im_s1;
	acc_t                    prior_re_s1, prior_im_s1;
	logic                    start_s1, last_s1;

	logic signed [MixW-1:0]  m_s2 [4];

	acc_t                    acc_re_q, acc_im_q;
	result_t                 sum_q;

	logic [CfgIdxW-1:0]      sel_re, sel_im;
	logic signed [SumW-1:0]  s_re, s_im;
	logic signed [CombW-1:0] x_re, x_im;
	logic signed [CombW-1:0] xr_re, xr_im;
	acc_t                    t_re, t_im, base_re, base_im, new_re, new_im;
	logic signed [AccW:0]    wide_re, wide_im;

	// Coefficient address: row, col, then real or imaginary.
	assign sel_re = {item.spinor_row, item.spinor_col, 1'b0};
	assign sel_im = {item.spinor_row, item.spinor_col, 1'b1};

	// First step: eight amplitude products, coefficient and flags captured.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_s1[0]     <= item.kdir_re * item.kpbase_re;
			p_s1[1]     <= item.kdir_im * item.kpbase_im;
			p_s1[2]     <= item.kbase_re * item.kpdir_re;
			p_s1[3]     <= item.kbase_im * item.kpdir_im;
			p_s1[4]     <= item.kdir_re * item.kpbase_im;
			p_s1[5]     <= item.kdir_im * item.kpbase_re;
			p_s1[6]     <= item.kbase_re * item.kpdir_im;
			p_s1[7]     <= item.kbase_im * item.kpdir_re;
			f_re_s1     <= signed'(coefs[sel_re]);
			f_im_s1     <= signed'(coefs[sel_im]);
			prior_re_s1 <= item.prior_re;
			prior_im_s1 <= item.prior_im;
			start_s1    <= !item.spinor_row && !item.spinor_col;
			last_s1     <= (item.spinor_row == LastIdx) && (item.spinor_col == LastIdx);
		end
	end

	assign stat.last = last_s1;

	// Second step: exact bilinear sum, then times the coefficient.
	assign s_re = SumW'(p_s1[0]) - SumW'(p_s1[1]) + SumW'(p_s1[2]) - SumW'(p_s1[3]);
	assign s_im = SumW'(p_s1[4]) + SumW'(p_s1[5]) + SumW'(p_s1[6]) + SumW'(p_s1[7]);

	always_ff @(posedge clk) begin
		if (cmd.mix) begin
			m_s2[0] <= f_re_s1 * s_re;
			m_s2[1] <= f_im_s1 * s_im;
			m_s2[2] <= f_re_s1 * s_im;
			m_s2[3] <= f_im_s1 * s_re;
		end
	end

	// Third step: combine, round half up to 24 fractional bits, accumulate.
	assign x_re  = CombW'(m_s2[0]) - CombW'(m_s2[1]);
	assign x_im  = CombW'(m_s2[2]) + CombW'(m_s2[3]);
	assign xr_re = (x_re + RndHalf) >>> RndShift;
	assign xr_im = (x_im + RndHalf) >>> RndShift;
	assign t_re  = xr_re[AccW-1:0];
	assign t_im  = xr_im[AccW-1:0];

	// The start pair begins from the prior value instead of the accumulator.
	assign base_re = start_s1 ? prior_re_s1 : acc_re_q;
	assign base_im = start_s1 ? prior_im_s1 : acc_im_q;
	assign wide_re = (AccW+1)'(base_re) + (AccW+1)'(t_re);
	assign wide_im = (AccW+1)'(base_im) + (AccW+1)'(t_im);

	// Saturate to the accumulator range when the top two bits disagree.
	always_comb begin
		new_re = wide_re[AccW-1:0];
		new_im = wide_im[AccW-1:0];
		if (wide_re[AccW] != wide_re[AccW-1]) begin
			new_re = {wide_re[AccW], {(AccW-1){!wide_re[AccW]}}};
		end
		if (wide_im[AccW] != wide_im[AccW-1]) begin
			new_im = {wide_im[AccW], {(AccW-1){!wide_im[AccW]}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (cmd.acc) begin
			acc_re_q <= new_re;
			acc_im_q <= new_im;
		end
	end

	// Output register holds the result word until it is taken.
	always_ff @(posedge clk) begin
		if (out_load) begin
			sum_q.sum_re <= new_re;
			sum_q.sum_im <= new_im;
		end
	end

	assign result = sum_q;

endmodule

@@ sv/spinor_bilinear_complex_mac_top.sv @@
// Top level of the spinor bilinear complex MAC.
// Each accepted word adds coef[row][col] * (kdir*kpbase + kbase*kpdir) to a 40-bit
// saturating complex accumulator, which restarts from the prior value on pair (0,0);
// after the last pair a sum word is produced. An item passes through three steps: the
// input edge computes the eight amplitude products, MIX the coefficient multiply, and
// ACC rounds and accumulates; no new word is taken until the previous one leaves ACC.
// A finished sum waits in an output register while the next word is processed; only a
// following last pair stalls while that register is still full. The user must write
// coefficients over the APB port only while the block is idle; nothing enforces it.
module spinor_bilinear_complex_mac_top import spbcm_pkg::*; #(
	parameter int SPINOR_COUNT = DefSpinorCount
) (
	input  logic                clk,
	input  logic                arst_n,
	spbcm_item_if.sink          item,
	spbcm_result_if.source      result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready
);

	coef_bank_t coefs;
	ctrl_cmd_t  cmd;
	dp_stat_t   stat;
	logic       out_load;

	spbcm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coefs   (coefs)
	);

	spbcm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.stat         (stat),
		.cmd          (cmd),
		.out_load     (out_load)
	);

	spbcm_dp #(
		.SPINOR_COUNT (SPINOR_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.out_load (out_load),
		.item     (item.word),
		.coefs    (coefs),
		.stat     (stat),
		.result   (result.word)
	);

endmodule

@@ bench/spbcm_checker.sv @@
// Watches the channels and the APB port, predicts each sum word and compares it.
module spbcm_checker import spbcm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	spbcm_item_if               item,
	spbcm_result_if             result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output int                  errors,
	output int                  outstanding
);

	localparam int     LastIdx    = DefSpinorCount - 1;
	localparam int     MaxReports = 10;
	localparam longint AccMax     = (longint'(1) <<< (AccW - 1)) - 1;
	localparam longint AccMin     = -AccMax - 1;

	// Local copy of the coefficient bank and of the accumulator.
	amp_t    coef_re [2][2];
	amp_t    coef_im [2][2];
	longint  acc_re;
	longint  acc_im;
	result_t sums_due[$];
	result_t due;
	int      err_cnt = 0;
	logic [CfgIdxW-1:0] reg_idx;

	initial begin
		errors = 0;
		outstanding = 0;
	end

	function automatic longint sat_acc(input longint x);
		if (x > AccMax)
			return AccMax;
		if (x < AccMin)
			return AccMin;
		return x;
	endfunction

	// Round a Q.36 value to Q.24, half up.
	function automatic longint round_q24(input longint x);
		return (x + (longint'(1) <<< (RndShift - 1))) >>> RndShift;
	endfunction

	// Fold one spinor pair into the accumulator; queue a sum on the last pair.
	function automatic void accumulate_pair(input item_t w);
		longint kb_re, kb_im, kd_re, kd_im, pb_re, pb_im, pd_re, pd_im;
		longint s_re, s_im, f_re, f_im, t_re, t_im;
		kb_re = $signed(w.kbase_re);
		kb_im = $signed(w.kbase_im);
		kd_re = $signed(w.kdir_re);
		kd_im = $signed(w.kdir_im);
		pb_re = $signed(w.kpbase_re);
		pb_im = $signed(w.kpbase_im);
		pd_re = $signed(w.kpdir_re);
		pd_im = $signed(w.kpdir_im);
		s_re = (kd_re * pb_re - kd_im * pb_im) + (kb_re * pd_re - kb_im * pd_im);
		s_im = (kd_re * pb_im + kd_im * pb_re) + (kb_re * pd_im + kb_im * pd_re);
		f_re = $signed(coef_re[w.spinor_row][w.spinor_col]);
		f_im = $signed(coef_im[w.spinor_row][w.spinor_col]);
		t_re = round_q24(f_re * s_re - f_im * s_im);
		t_im = round_q24(f_re * s_im + f_im * s_re);
		if (w.spinor_row == 1'b0 && w.spinor_col == 1'b0) begin
			acc_re = $signed(w.prior_re);
			acc_im = $signed(w.prior_im);
		end
		acc_re = sat_acc(acc_re + t_re);
		acc_im = sat_acc(acc_im + t_im);
		if (int'(w.spinor_row) == LastIdx && int'(w.spinor_col) == LastIdx)
			sums_due.push_back('{sum_re: acc_t'(acc_re), sum_im: acc_t'(acc_im)});
	endfunction

	function automatic void note_fail(input string msg);
		err_cnt++;
		if (err_cnt <= MaxReports)
			$display("%t: %s", $realtime, msg);
	endfunction

	// Results are checked before the new word is folded in, since a sum never
	// comes from the word accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 2; r++)
				for (int c = 0; c < 2; c++) begin
					coef_re[r][c] = '0;
					coef_im[r][c] = '0;
				end
			acc_re = 0;
			acc_im = 0;
			sums_due.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (sums_due.size() == 0) begin
					note_fail($sformatf("unexpected sum word re=%0d im=%0d",
						result.word.sum_re, result.word.sum_im));
				end else begin
					due = sums_due.pop_front();
					if (result.word.sum_re !== due.sum_re)
						note_fail($sformatf("sum_re mismatch: expected %0d, got %0d",
							due.sum_re, result.word.sum_re));
					if (result.word.sum_im !== due.sum_im)
						note_fail($sformatf("sum_im mismatch: expected %0d, got %0d",
							due.sum_im, result.word.sum_im));
				end
			end
			// Register index bits: row, column, imaginary.
			if (psel && penable && pwrite && pready) begin
				reg_idx = paddr[CfgAddrW-1:2];
				if (reg_idx[0])
					coef_im[reg_idx[2]][reg_idx[1]] = amp_t'(pwdata[AmpW-1:0]);
				else
					coef_re[reg_idx[2]][reg_idx[1]] = amp_t'(pwdata[AmpW-1:0]);
			end
			if (item.valid && item.ready)
				accumulate_pair(item.word);
		end
		errors <= err_cnt;
		outstanding <= sums_due.size();
	end

endmodule

@@ bench/tb_spinor_bilinear_complex_mac_top.sv @@
// Stimulus and verdict for the spinor bilinear complex MAC.
module tb_spinor_bilinear_complex_mac_top;
	import spbcm_pkg::*;

	localparam int   ClkHalf     = 10;
	localparam int   HoldCycles  = 300;
	localparam int   DrainCycles = 8;
	localparam int   SegItems    = 260;
	localparam amp_t AmpMax      = 16'sh7fff;
	localparam amp_t AmpMin      = 16'sh8000;
	localparam acc_t AccMax      = {1'b0, {(AccW - 1){1'b1}}};
	localparam acc_t AccMin      = {1'b1, {(AccW - 1){1'b0}}};

	typedef enum int {
		COEF_00_RE, COEF_00_IM, COEF_01_RE, COEF_01_IM,
		COEF_10_RE, COEF_10_IM, COEF_11_RE, COEF_11_IM
	} coef_reg_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [CfgAddrW-1:0] paddr;
	logic [CfgDataW-1:0] pwdata;
	logic [CfgDataW-1:0] prdata;
	logic                pready;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_asks = 0;
	int   errors;
	int   outstanding;
	amp_t coef_set [CfgRegs];

	spbcm_item_if   item_ch ();
	spbcm_result_if result_ch ();

	spinor_bilinear_complex_mac_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	spbcm_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #ClkHalf clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Sum word receiver: random back-pressure, plus a long hold-off on request.
	initial begin
		int hold_seen;
		hold_seen = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				result_ch.ready <= 1'b0;
				repeat (HoldCycles - 1) @(posedge clk);
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	function automatic amp_t rand_amp();
		case ($urandom_range(0, 9))
			0: return AmpMax;
			1: return AmpMin;
			2, 3: return amp_t'(int'($urandom_range(0, 32)) - 16);
			default: return amp_t'($urandom);
		endcase
	endfunction

	function automatic acc_t rand_acc();
		case ($urandom_range(0, 9))
			0: return AccMax;
			1: return AccMin;
			2, 3: return acc_t'(longint'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return acc_t'({$urandom, $urandom});
		endcase
	endfunction

	function automatic item_t rand_item(input logic r, input logic c);
		item_t w;
		w.kbase_re   = rand_amp();
		w.kbase_im   = rand_amp();
		w.kdir_re    = rand_amp();
		w.kdir_im    = rand_amp();
		w.kpbase_re  = rand_amp();
		w.kpbase_im  = rand_amp();
		w.kpdir_re   = rand_amp();
		w.kpdir_im   = rand_amp();
		w.prior_re   = rand_acc();
		w.prior_im   = rand_acc();
		w.spinor_row = r;
		w.spinor_col = c;
		return w;
	endfunction

	// Every amplitude set to one value and both prior parts to another.
	function automatic item_t flat(input logic r, input logic c, input amp_t a, input acc_t p);
		return '{kbase_re: a, kbase_im: a, kdir_re: a, kdir_im: a,
			kpbase_re: a, kpbase_im: a, kpdir_re: a, kpdir_im: a,
			prior_re: p, prior_im: p, spinor_row: r, spinor_col: c};
	endfunction

	task automatic send_word(input item_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.word  <= w;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	// Stop offering and wait until every sum word has come back.
	task automatic drain_all();
		item_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Back-to-back APB writes of the whole bank; upper data bits are junk.
	task automatic write_coefs();
		for (int i = 0; i < CfgRegs; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= CfgAddrW'(i << 2);
			pwdata  <= {16'($urandom), coef_set[i]};
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly complete pair sequences, some with pairs dropped, some lone pairs.
	task automatic run_segment(input int n_items, input bit with_hold);
		int sent;
		int pick;
		bit held;
		sent = 0;
		held = 1'b0;
		while (sent < n_items) begin
			if (with_hold && !held && sent >= 16) begin
				hold_asks++;
				held = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				for (int k = 0; k < 4; k++)
					send_word(rand_item(k[1], k[0]));
				sent += 4;
			end else if (pick < 88) begin
				for (int k = 0; k < 4; k++)
					if ($urandom_range(0, 3) != 0) begin
						send_word(rand_item(k[1], k[0]));
						sent++;
					end
			end else begin
				send_word(rand_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
				sent++;
			end
		end
	endtask

	initial begin
		item_t w;
		int    send_pct [3];
		int    recv_pct [3];
		send_pct = '{37, 54, 0};
		recv_pct = '{54, 37, 0};
		arst_n        <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.word  <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = send_pct[0];
		recv_idle_pct = recv_pct[0];

		// Coefficients still at reset: the sum is just the prior.
		send_word(rand_item(1'b0, 1'b0));
		send_word(rand_item(1'b1, 1'b1));
		drain_all();

		// Extreme coefficients and amplitudes drive the accumulator into saturation.
		coef_set[COEF_00_RE] = AmpMax;
		coef_set[COEF_00_IM] = AmpMin;
		coef_set[COEF_01_RE] = AmpMin;
		coef_set[COEF_01_IM] = AmpMax;
		coef_set[COEF_10_RE] = AmpMax;
		coef_set[COEF_10_IM] = AmpMax;
		coef_set[COEF_11_RE] = AmpMin;
		coef_set[COEF_11_IM] = AmpMin;
		write_coefs();
		for (int k = 0; k < 4; k++)
			send_word(flat(k[1], k[0], AmpMax, AccMax));
		for (int k = 0; k < 4; k++)
			send_word(flat(k[1], k[0], AmpMin, AccMin));
		for (int k = 0; k < 4; k++) begin
			w = flat(k[1], k[0], AmpMax, '0);
			w.kdir_re   = AmpMin;
			w.kdir_im   = AmpMin;
			w.kpbase_im = AmpMin;
			w.kpdir_re  = AmpMin;
			send_word(w);
		end
		// A last pair with no start pair keeps adding to the old value.
		send_word(rand_item(1'b1, 1'b1));
		// Pairs out of order just accumulate; the start pair reloads the prior.
		send_word(rand_item(1'b1, 1'b0));
		send_word(rand_item(1'b0, 1'b1));
		send_word(rand_item(1'b0, 1'b0));
		send_word(rand_item(1'b1, 1'b1));
		drain_all();

		// Unit coefficients put the rounding step right on its edges.
		coef_set[COEF_00_RE] = 16'sd1;
		coef_set[COEF_00_IM] = 16'sd0;
		coef_set[COEF_01_RE] = 16'sd0;
		coef_set[COEF_01_IM] = 16'sd1;
		coef_set[COEF_10_RE] = -16'sd1;
		coef_set[COEF_10_IM] = 16'sd0;
		coef_set[COEF_11_RE] = 16'sd1;
		coef_set[COEF_11_IM] = -16'sd1;
		write_coefs();
		w = flat(1'b0, 1'b0, '0, '0);
		w.kdir_re   = 16'sd1;
		w.kpbase_re = 16'sd2048;
		send_word(w);
		w = flat(1'b0, 1'b1, '0, AccMax);
		w.kdir_re   = -16'sd1;
		w.kpbase_re = 16'sd2048;
		send_word(w);
		w = flat(1'b1, 1'b0, '0, AccMin);
		w.kdir_re   = 16'sd1;
		w.kpbase_re = 16'sd2049;
		send_word(w);
		w = flat(1'b1, 1'b1, '0, '0);
		w.kbase_re = 16'sd1;
		w.kpdir_re = 16'sd6143;
		send_word(w);
		send_word(flat(1'b0, 1'b0, '0, rand_acc()));
		send_word(flat(1'b1, 1'b1, '0, rand_acc()));

		// Random part: three idle patterns, two coefficient sets each.
		for (int ph = 0; ph < 3; ph++) begin
			for (int sg = 0; sg < 2; sg++) begin
				drain_all();
				send_idle_pct = send_pct[ph];
				recv_idle_pct = recv_pct[ph];
				for (int i = 0; i < CfgRegs; i++)
					coef_set[i] = rand_amp();
				write_coefs();
				run_segment(SegItems, (ph == 2 && sg == 0) || (ph == 0 && sg == 1));
			end
		end

		drain_all();
		if (errors == 0 && outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
